/* design/fenwick_prefix_sum_table_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef FENWICK_PREFIX_SUM_TABLE_TOP_DEFINES_SVH
`define FENWICK_PREFIX_SUM_TABLE_TOP_DEFINES_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define FPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
  `FPS_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* design/fps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned KEY_W   = 12;
  localparam int unsigned PADDR_W = 3;

  localparam logic [SIZE_W-1:0] USED_SIZE_RST = 11'd1024;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_USED_SIZE = 1'b0
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } back_state_e;

  typedef struct packed {
    opcode_e           op;
    logic              oor;
    logic [KEY_W-1:0]  k;
    logic [DATA_W-1:0] value;
    logic [SIZE_W-1:0] n;
  } cmd_t;

endpackage

`default_nettype wire

/* design/fps_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fps_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [fps_pkg::INDEX_W-1:0]        item_index;
  logic signed [fps_pkg::DATA_W-1:0]  add_value;

  modport source (output valid, opcode, item_index, add_value, input ready);
  modport sink   (input valid, opcode, item_index, add_value, output ready);
endinterface

`default_nettype wire

/* design/fps_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fps_pkg::DATA_W-1:0]  prefix_sum;
  logic                               out_of_range;

  modport source (output valid, prefix_sum, out_of_range, input ready);
  modport sink   (input valid, prefix_sum, out_of_range, output ready);
endinterface

`default_nettype wire

/* design/fps_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/fps_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module fps_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire fps_pkg::cmd_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output fps_pkg::cmd_t      pop_data_o
);

  localparam int unsigned DEPTH = 2;

  fps_pkg::cmd_t entries_q [DEPTH];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entries_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/fps_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module fps_front #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [fps_pkg::INDEX_W-1:0]   item_index_i,
  input  wire logic [fps_pkg::DATA_W-1:0]    add_value_i,
  input  wire logic [fps_pkg::SIZE_W-1:0]    used_size_i,
  input  wire logic                          clearing_i,
  output logic                               cmd_valid_o,
  output fps_pkg::cmd_t                      cmd_o,
  input  wire logic                          cmd_ready_i
);

  logic [fps_pkg::SIZE_W-1:0] eff_size;
  logic                       beyond;
  fps_pkg::opcode_e           op;

  // used_size saturates at the tree capacity
  assign eff_size = (int'(used_size_i) > MAX_POSITIONS) ?
                    fps_pkg::SIZE_W'(MAX_POSITIONS) : used_size_i;
  assign beyond   = (fps_pkg::SIZE_W'(item_index_i) >= eff_size);
  assign op       = fps_pkg::opcode_e'(opcode_i);

  assign in_ready_o = cmd_ready_i && !clearing_i;

  // adds beyond the size are taken and dropped here
  assign cmd_valid_o = in_valid_i && !clearing_i && !(op == fps_pkg::OP_ADD && beyond);

  always_comb begin
    cmd_o.op    = op;
    cmd_o.oor   = (op == fps_pkg::OP_QUERY) && beyond;
    cmd_o.k     = fps_pkg::KEY_W'(item_index_i) + fps_pkg::KEY_W'(1);
    cmd_o.value = add_value_i;
    cmd_o.n     = eff_size;
  end

endmodule

`default_nettype wire

/* design/fps_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module fps_back #(
  parameter int unsigned MAX_POSITIONS = 1024,
  localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire fps_pkg::cmd_t               cmd_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [fps_pkg::DATA_W-1:0]       prefix_sum_o,
  output logic                             out_of_range_o,
  output logic                             clearing_o
);

  localparam int unsigned KW = fps_pkg::KEY_W;
  localparam int unsigned DW = fps_pkg::DATA_W;

  fps_pkg::back_state_e     state_q, state_d;
  logic [AW-1:0]            clr_cnt_q, clr_cnt_d;
  logic [KW-1:0]            k_q, k_d;
  logic [DW-1:0]            acc_q, acc_d;
  fps_pkg::opcode_e         op_q, op_d;
  logic [DW-1:0]            val_q, val_d;
  logic [fps_pkg::SIZE_W-1:0] n_q, n_d;
  logic                     oor_q, oor_d;
  logic                     pend_q, pend_d;
  logic [AW-1:0]            paddr_q, paddr_d;
  logic                     out_valid_q, out_valid_d;
  logic [DW-1:0]            out_sum_q, out_sum_d;
  logic                     out_oor_q, out_oor_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [DW-1:0]            ram_rdata;
  logic [KW-1:0]            low_bit;
  logic [KW-1:0]            k_next;
  logic                     walk_active;

  fps_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_POSITIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign low_bit     = k_q & (~k_q + KW'(1));
  assign k_next      = (op_q == fps_pkg::OP_ADD) ? (k_q + low_bit) : (k_q - low_bit);
  assign walk_active = (op_q == fps_pkg::OP_ADD) ? (k_q <= KW'(n_q)) : (k_q != '0);
  assign ram_raddr   = AW'(k_q - KW'(1));

  assign cmd_ready_o    = (state_q == fps_pkg::ST_IDLE);
  assign clearing_o     = (state_q == fps_pkg::ST_CLEAR);
  assign out_valid_o    = out_valid_q;
  assign prefix_sum_o   = out_sum_q;
  assign out_of_range_o = out_oor_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    k_d         = k_q;
    acc_d       = acc_q;
    op_d        = op_q;
    val_d       = val_q;
    n_d         = n_q;
    oor_d       = oor_q;
    pend_d      = pend_q;
    paddr_d     = paddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sum_d   = out_sum_q;
    out_oor_d   = out_oor_q;
    ram_we      = 1'b0;
    ram_waddr   = paddr_q;
    ram_wdata   = ram_rdata + val_q;

    unique case (state_q)
      fps_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MAX_POSITIONS - 1)) begin
          state_d = fps_pkg::ST_IDLE;
        end
      end
      fps_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          k_d     = cmd_i.k;
          op_d    = cmd_i.op;
          val_d   = cmd_i.value;
          n_d     = cmd_i.n;
          oor_d   = cmd_i.oor;
          acc_d   = '0;
          pend_d  = 1'b0;
          state_d = cmd_i.oor ? fps_pkg::ST_DONE : fps_pkg::ST_WALK;
        end
      end
      fps_pkg::ST_WALK: begin
        // node read last cycle: update it (add) or accumulate it (query)
        if (pend_q) begin
          if (op_q == fps_pkg::OP_ADD) begin
            ram_we = 1'b1;
          end else begin
            acc_d = acc_q + ram_rdata;
          end
        end
        if (walk_active) begin
          pend_d  = 1'b1;
          paddr_d = ram_raddr;
          k_d     = k_next;
        end else begin
          pend_d  = 1'b0;
          state_d = (op_q == fps_pkg::OP_ADD) ? fps_pkg::ST_IDLE : fps_pkg::ST_DONE;
        end
      end
      fps_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_oor_d   = oor_q;
          state_d     = fps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fps_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    acc_q     <= acc_d;
    op_q      <= op_d;
    val_q     <= val_d;
    n_q       <= n_d;
    oor_q     <= oor_d;
    paddr_q   <= paddr_d;
    out_sum_q <= out_sum_d;
    out_oor_q <= out_oor_d;
  end

endmodule

`default_nettype wire

/* design/fenwick_prefix_sum_table_top.sv */
// Add: the walk reads one tree node per cycle on the RAM read port.
// Query: the walk reads the nodes on the downward chain, then the result is registered once the output is free;
// a query at or beyond the used size skips the walk and returns a zero sum flagged out of range.
// One item is walked at a time; a 2-entry queue takes new items meanwhile.
// Reset: used_size returns to 1024; a clearing pass zeroes all MAX_POSITIONS tree
// nodes, with in_i.ready low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module fenwick_prefix_sum_table_top #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  fps_in_if.sink                            in_i,
  fps_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fps_pkg::DATA_W-1:0]   pwdata,
  output logic      [fps_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [fps_pkg::SIZE_W-1:0] used_size_q, used_size_d;
  logic                       reg_sel;
  logic                       cfg_write;
  logic                       clearing;

  logic          fr_valid, fr_ready;
  fps_pkg::cmd_t fr_cmd;
  logic          bk_valid, bk_ready;
  fps_pkg::cmd_t bk_cmd;

  assign pready    = 1'b1;
  assign reg_sel   = (paddr[fps_pkg::PADDR_W-1] == fps_pkg::REG_USED_SIZE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? fps_pkg::DATA_W'(used_size_q) : '0;

  always_comb begin
    used_size_d = used_size_q;
    if (cfg_write && reg_sel) begin
      used_size_d = pwdata[fps_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= fps_pkg::USED_SIZE_RST;
    end else begin
      used_size_q <= used_size_d;
    end
  end

  fps_front #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_front (
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .opcode_i     (in_i.opcode),
    .item_index_i (in_i.item_index),
    .add_value_i  (in_i.add_value),
    .used_size_i  (used_size_q),
    .clearing_i   (clearing),
    .cmd_valid_o  (fr_valid),
    .cmd_o        (fr_cmd),
    .cmd_ready_i  (fr_ready)
  );

  fps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  fps_back #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bk_valid),
    .cmd_ready_o    (bk_ready),
    .cmd_i          (bk_cmd),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .prefix_sum_o   (out_o.prefix_sum),
    .out_of_range_o (out_o.out_of_range),
    .clearing_o     (clearing)
  );

endmodule

`default_nettype wire

/* design/fps_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fenwick_prefix_sum_table_top_defines.svh"

module fps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [fps_pkg::DATA_W-1:0]   out_sum_i,
  input wire logic                         out_oor_i,
  input wire logic                         psel_i,
  input wire logic                         penable_i,
  input wire logic                         pwrite_i,
  input wire logic                         pready_i,
  input wire logic [fps_pkg::PADDR_W-1:0]  paddr_i,
  input wire logic [fps_pkg::DATA_W-1:0]   pwdata_i,
  input wire logic [fps_pkg::DATA_W-1:0]   prdata_i
);

  `FPS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i) && $stable(out_oor_i), "result changed while stalled")

  `FPS_ASSERT(a_oor_zero, out_valid_i && out_oor_i |-> out_sum_i == '0, "out of range result with nonzero sum")

  `FPS_ASSERT_NEXT(a_cfg_readback, psel_i && penable_i && pwrite_i && pready_i && !paddr_i[fps_pkg::PADDR_W-1], paddr_i[fps_pkg::PADDR_W-1] || prdata_i[fps_pkg::SIZE_W-1:0] == $past(pwdata_i[fps_pkg::SIZE_W-1:0]), "used_size readback mismatch")

endmodule

bind fenwick_prefix_sum_table_top fps_checker u_fps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sum_i   (out_o.prefix_sum),
  .out_oor_i   (out_o.out_of_range),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .pready_i    (pready),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire
